// File: hw/rtl/rotation_matrix_to_quaternion_macros.svh
// assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RMQ_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("rmq assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define RMQ_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("rmq assertion failed");

`endif

// File: hw/rtl/rmq_pkg.sv
// shared constants and types of the rotation matrix to quaternion block
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ELEM_W    = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int ELEM_MAG  = 1 << (ELEM_W - 1);
  localparam int ARG_W     = $clog2(3 * ELEM_MAG + ONE + 1);
  localparam int RAD_W     = ARG_W + FRAC_BITS;
  localparam int ROOT_W    = (RAD_W + 1) / 2;
  localparam int NUMD_W    = ELEM_W + 1;
  localparam int D_W       = ROOT_W + 1;
  localparam int QW        = FRAC_BITS + 2;
  localparam int NUM_W     = NUMD_W + FRAC_BITS + 1;
  localparam int REM_W     = (NUM_W > D_W + QW) ? NUM_W : D_W + QW;

  typedef enum logic [1:0] {
    SLOT_W,
    SLOT_X,
    SLOT_Y,
    SLOT_Z
  } slot_e;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [NUMD_W-1:0] numd_t;

  typedef struct packed {
    logic [ARG_W-1:0] arg;
    numd_t [2:0]      num;
    slot_e            slot;
  } front_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    numd_t [2:0]       num;
    slot_e             slot;
  } root_t;

  typedef struct packed {
    elem_t qw;
    elem_t qx;
    elem_t qy;
    elem_t qz;
  } quat_t;

endpackage

// File: hw/rtl/rmq_if.sv
// request and result channels of the rotation matrix to quaternion block
interface rmq_mat_if;
  logic          valid;
  logic          ready;
  rmq_pkg::elem_t m00;
  rmq_pkg::elem_t m01;
  rmq_pkg::elem_t m02;
  rmq_pkg::elem_t m10;
  rmq_pkg::elem_t m11;
  rmq_pkg::elem_t m12;
  rmq_pkg::elem_t m20;
  rmq_pkg::elem_t m21;
  rmq_pkg::elem_t m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_quat_if;
  logic          valid;
  logic          ready;
  rmq_pkg::elem_t qw;
  rmq_pkg::elem_t qx;
  rmq_pkg::elem_t qy;
  rmq_pkg::elem_t qz;

  modport source (output valid, qw, qx, qy, qz, input ready);
  modport sink (input valid, qw, qx, qy, qz, output ready);
endinterface

// File: hw/rtl/rmq_front.sv
// front stage: trace, branch choice, root argument and numerators
`include "rotation_matrix_to_quaternion_macros.svh"

module rmq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  rmq_mat_if.sink         mat_i,
  output logic            vld_o,
  input  logic            rdy_i,
  output rmq_pkg::front_t data_o
);

  localparam int AW = rmq_pkg::ARG_W + 3;
  localparam int NW = rmq_pkg::NUMD_W;
  localparam logic signed [AW-1:0] ONE_S = AW'(rmq_pkg::ONE);

  logic             vld_q;
  rmq_pkg::front_t  data_q, data_d;
  logic signed [AW-1:0] tr, dii, arg_s;
  logic             pos, sel1, sel2;
  rmq_pkg::elem_t   mii;
  rmq_pkg::numd_t   n0, n1, n2;
  logic             rdy;

  assign rdy         = !vld_q || rdy_i;
  assign mat_i.ready = rdy;

  always_comb begin
    tr    = AW'(mat_i.m00) + AW'(mat_i.m11) + AW'(mat_i.m22);
    pos   = tr > AW'(0);
    sel1  = mat_i.m11 > mat_i.m00;
    mii   = sel1 ? mat_i.m11 : mat_i.m00;
    sel2  = mat_i.m22 > mii;
    dii   = sel2 ? AW'(mat_i.m22) : AW'(mii);
    arg_s = pos ? tr + ONE_S : (dii <<< 1) - tr + ONE_S;
    data_d.arg = (arg_s < AW'(1)) ? rmq_pkg::ARG_W'(1) : rmq_pkg::ARG_W'(arg_s);
    if (pos) begin
      data_d.slot = rmq_pkg::SLOT_W;
    end else if (sel2) begin
      data_d.slot = rmq_pkg::SLOT_Z;
    end else if (sel1) begin
      data_d.slot = rmq_pkg::SLOT_Y;
    end else begin
      data_d.slot = rmq_pkg::SLOT_X;
    end
    case (data_d.slot)
      rmq_pkg::SLOT_X: begin
        n0 = NW'(mat_i.m21) - NW'(mat_i.m12);
        n1 = NW'(mat_i.m10) + NW'(mat_i.m01);
        n2 = NW'(mat_i.m20) + NW'(mat_i.m02);
      end
      rmq_pkg::SLOT_Y: begin
        n0 = NW'(mat_i.m02) - NW'(mat_i.m20);
        n1 = NW'(mat_i.m21) + NW'(mat_i.m12);
        n2 = NW'(mat_i.m01) + NW'(mat_i.m10);
      end
      rmq_pkg::SLOT_Z: begin
        n0 = NW'(mat_i.m10) - NW'(mat_i.m01);
        n1 = NW'(mat_i.m02) + NW'(mat_i.m20);
        n2 = NW'(mat_i.m12) + NW'(mat_i.m21);
      end
      default: begin
        n0 = NW'(mat_i.m21) - NW'(mat_i.m12);
        n1 = NW'(mat_i.m02) - NW'(mat_i.m20);
        n2 = NW'(mat_i.m10) - NW'(mat_i.m01);
      end
    endcase
    data_d.num[0] = n0;
    data_d.num[1] = n1;
    data_d.num[2] = n2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy) begin
      vld_q <= mat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && mat_i.valid) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

  `RMQ_ASSERT_NEXT(a_front_hold, vld_q && !rdy_i, vld_q && $stable(data_q))

endmodule

// File: hw/rtl/rmq_sqrt.sv
// pipelined integer square root, two radicand bits per stage
`include "rotation_matrix_to_quaternion_macros.svh"

module rmq_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  output logic            rdy_o,
  input  rmq_pkg::front_t data_i,
  output logic            vld_o,
  input  logic            rdy_i,
  output rmq_pkg::root_t  data_o
);

  localparam int S     = rmq_pkg::ROOT_W;
  localparam int RW    = rmq_pkg::ROOT_W;
  localparam int PAD_W = 2 * RW;
  localparam int FB    = rmq_pkg::FRAC_BITS;

  logic [S-1:0]    vld_q;
  logic [S-1:0]    pv;
  logic [S:0]      rdy;
  logic [RW+1:0]   rem_q  [S];
  logic [RW-1:0]   root_q [S];
  rmq_pkg::front_t side_q [S];

  assign rdy[S] = rdy_i;
  assign pv     = {vld_q[S-2:0], vld_i};
  assign rdy_o  = rdy[0];

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [RW+1:0]   rem_p, shifted, trial;
    logic [RW-1:0]   root_p;
    rmq_pkg::front_t side_p;
    logic [PAD_W-1:0] rad;
    logic [1:0]      two;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = data_i;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign side_p = side_q[s-1];
    end

    assign rdy[s]  = !vld_q[s] || rdy[s+1];
    assign rad     = PAD_W'({side_p.arg, {FB{1'b0}}});
    assign two     = rad[PAD_W-1-2*s -: 2];
    assign shifted = {rem_p[RW-1:0], two};
    assign trial   = {root_p, 2'b01};
    assign ge      = shifted >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= pv[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && pv[s]) begin
        rem_q[s]  <= ge ? shifted - trial : shifted;
        root_q[s] <= {root_p[RW-2:0], ge};
        side_q[s] <= side_p;
      end
    end
  end

  assign vld_o       = vld_q[S-1];
  assign data_o.root = root_q[S-1];
  assign data_o.num  = side_q[S-1].num;
  assign data_o.slot = side_q[S-1].slot;

  // consistency of the final root and remainder
  logic [PAD_W+1:0] sq_chk, rad_last;
  logic [RW+1:0]    root2;

  assign sq_chk   = (PAD_W+2)'(root_q[S-1]) * (PAD_W+2)'(root_q[S-1])
                  + (PAD_W+2)'(rem_q[S-1]);
  assign rad_last = (PAD_W+2)'({side_q[S-1].arg, {FB{1'b0}}});
  assign root2    = (RW+2)'({root_q[S-1], 1'b0});

  `RMQ_ASSERT_IMP(a_sqrt_exact, vld_q[S-1], sq_chk == rad_last)
  `RMQ_ASSERT_IMP(a_sqrt_floor, vld_q[S-1], rem_q[S-1] <= root2)

endmodule

// File: hw/rtl/rmq_div.sv
// pipelined rounding divide of three lanes, saturation and output placement
`include "rotation_matrix_to_quaternion_macros.svh"

module rmq_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  output logic           rdy_o,
  input  rmq_pkg::root_t data_i,
  output logic           vld_o,
  input  logic           rdy_i,
  output rmq_pkg::quat_t data_o
);

  localparam int QW  = rmq_pkg::QW;
  localparam int RW  = rmq_pkg::ROOT_W;
  localparam int REM = rmq_pkg::REM_W;
  localparam int EW  = rmq_pkg::ELEM_W;
  localparam int FB  = rmq_pkg::FRAC_BITS;
  localparam int NW  = rmq_pkg::NUMD_W;
  localparam int S   = QW + 3;

  typedef struct packed {
    logic [2:0][REM-1:0] rem;
    logic [2:0][QW-1:0]  q;
    logic [2:0]          ovf;
    logic [2:0]          neg;
    logic [RW-1:0]       root;
    rmq_pkg::slot_e      slot;
  } div_t;

  function automatic rmq_pkg::elem_t sat_lane(logic [QW-1:0] q, logic ovf, logic neg);
    logic [QW-1:0] m;
    m = (ovf || q > QW'(rmq_pkg::ONE)) ? QW'(rmq_pkg::ONE) : q;
    return neg ? -EW'(m) : EW'(m);
  endfunction

  logic [S-1:0]   vld_q;
  logic [S-1:0]   pv;
  logic [S:0]     rdy;
  div_t           st_q [S-1];
  div_t           st_d [S-1];
  rmq_pkg::quat_t out_q, out_d;

  assign rdy[S] = rdy_i;
  assign pv     = {vld_q[S-2:0], vld_i};
  assign rdy_o  = rdy[0];

  // magnitude, rounding offset and sign
  always_comb begin
    rmq_pkg::numd_t n;
    logic [NW-1:0]  mag;
    st_d[0] = '0;
    st_d[0].root = data_i.root;
    st_d[0].slot = data_i.slot;
    for (int l = 0; l < 3; l++) begin
      n   = data_i.num[l];
      mag = (n < 0) ? NW'(-n) : NW'(n);
      st_d[0].neg[l] = n < 0;
      st_d[0].rem[l] = REM'({mag, {FB{1'b0}}}) + REM'(data_i.root);
    end
  end

  // quotient too large for the quotient width
  logic [REM-1:0] dovf;
  assign dovf = REM'({st_q[0].root, 1'b0}) << QW;

  always_comb begin
    st_d[1] = st_q[0];
    for (int l = 0; l < 3; l++) begin
      st_d[1].ovf[l] = st_q[0].rem[l] >= dovf;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam int B = QW - 1 - k;
    logic [REM-1:0] sh;
    assign sh = REM'({st_q[k+1].root, 1'b0}) << B;
    always_comb begin
      st_d[k+2] = st_q[k+1];
      for (int l = 0; l < 3; l++) begin
        if (st_q[k+1].rem[l] >= sh) begin
          st_d[k+2].rem[l]  = st_q[k+1].rem[l] - sh;
          st_d[k+2].q[l][B] = 1'b1;
        end
      end
    end
  end

  // saturation and placement of the root component
  always_comb begin
    div_t           f;
    logic [RW:0]    rh;
    rmq_pkg::elem_t rt, l0, l1, l2;
    f  = st_q[S-2];
    rh = ((RW+1)'(f.root) + (RW+1)'(1)) >> 1;
    rt = (rh > (RW+1)'(rmq_pkg::ONE)) ? EW'(rmq_pkg::ONE) : EW'(rh);
    l0 = sat_lane(f.q[0], f.ovf[0], f.neg[0]);
    l1 = sat_lane(f.q[1], f.ovf[1], f.neg[1]);
    l2 = sat_lane(f.q[2], f.ovf[2], f.neg[2]);
    case (f.slot)
      rmq_pkg::SLOT_X: out_d = '{qw: l0, qx: rt, qy: l1, qz: l2};
      rmq_pkg::SLOT_Y: out_d = '{qw: l0, qx: l2, qy: rt, qz: l1};
      rmq_pkg::SLOT_Z: out_d = '{qw: l0, qx: l1, qy: l2, qz: rt};
      default:         out_d = '{qw: rt, qx: l0, qy: l1, qz: l2};
    endcase
  end

  for (genvar s = 0; s < S; s++) begin : g_ctl
    assign rdy[s] = !vld_q[s] || rdy[s+1];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= pv[s];
      end
    end
  end

  for (genvar s = 0; s < S - 1; s++) begin : g_data
    always_ff @(posedge clk_i) begin
      if (rdy[s] && pv[s]) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[S-1] && pv[S-1]) begin
      out_q <= out_d;
    end
  end

  assign vld_o  = vld_q[S-1];
  assign data_o = out_q;

  // remainder bounds before and after the bit stages
  logic [REM-1:0] dfin;
  logic [REM-1:0] dovf1;
  logic           fin_ok;
  assign dfin   = REM'({st_q[S-2].root, 1'b0});
  assign dovf1  = REM'({st_q[1].root, 1'b0}) << QW;
  assign fin_ok = (st_q[S-2].ovf[0] || st_q[S-2].rem[0] < dfin)
               && (st_q[S-2].ovf[1] || st_q[S-2].rem[1] < dfin)
               && (st_q[S-2].ovf[2] || st_q[S-2].rem[2] < dfin);

  `RMQ_ASSERT_IMP(a_div_rem_final, vld_q[S-2], fin_ok)
  `RMQ_ASSERT_IMP(a_div_no_ovf, vld_q[1] && !st_q[1].ovf[0], st_q[1].rem[0] < dovf1)

endmodule

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// rotation matrix to quaternion, top level
// requests pass through the front stage, the root stages and the divide stages to the result
// throughput: one request per cycle while the output does not stall, set by the fully pipelined root and divide stages
// stalls collapse bubbles stage by stage, so nothing is lost or repeated
// reset clears only the stage valid bits; the datapath needs no reset
module rotation_matrix_to_quaternion (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmq_mat_if.sink     mat_i,
  rmq_quat_if.source  quat_o
);

  logic            f_vld, f_rdy, r_vld, r_rdy, d_vld;
  rmq_pkg::front_t f_data;
  rmq_pkg::root_t  r_data;
  rmq_pkg::quat_t  d_data;

  rmq_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mat_i  (mat_i),
    .vld_o  (f_vld),
    .rdy_i  (f_rdy),
    .data_o (f_data)
  );

  rmq_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (f_vld),
    .rdy_o  (f_rdy),
    .data_i (f_data),
    .vld_o  (r_vld),
    .rdy_i  (r_rdy),
    .data_o (r_data)
  );

  rmq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (r_vld),
    .rdy_o  (r_rdy),
    .data_i (r_data),
    .vld_o  (d_vld),
    .rdy_i  (quat_o.ready),
    .data_o (d_data)
  );

  assign quat_o.valid = d_vld;
  assign quat_o.qw    = d_data.qw;
  assign quat_o.qx    = d_data.qx;
  assign quat_o.qy    = d_data.qy;
  assign quat_o.qz    = d_data.qz;

endmodule

// File: dv/tb.sv
// testbench for the rotation matrix to quaternion block: directed table, random matrices, predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE       = rmq_pkg::ONE;
  localparam int FRAC_BITS = rmq_pkg::FRAC_BITS;

  typedef rmq_pkg::elem_t elem_t;
  typedef rmq_pkg::quat_t quat_t;

  typedef struct {
    elem_t m [9];
  } mat_t;

  typedef struct {
    mat_t m;
    logic chk;
    quat_t q;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic fail = 1'b0;
  bit quiet = 1'b0;
  int unsigned stall_n = 0;
  quat_t quat_due [$];
  row_t table_q [$];

  rmq_mat_if mat_if ();
  rmq_quat_if quat_if ();

  rotation_matrix_to_quaternion u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .mat_i (mat_if.sink),
    .quat_o(quat_if.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint unsigned mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic elem_t clamp_one(longint v);
    if (v > ONE) return elem_t'(ONE);
    if (v < -ONE) return elem_t'(-ONE);
    return elem_t'(v);
  endfunction

  function automatic longint root_of(longint a);
    longint r;
    if (a < 1) a = 1;
    r = longint'(int_sqrt(longint'(a) << FRAC_BITS));
    return (r < 1) ? 1 : r;
  endfunction

  function automatic quat_t to_quat(mat_t mt);
    longint m [3][3];
    longint q [4];
    longint tr, r, d;
    int i, j, k;
    quat_t o;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) m[a][b] = mt.m[a*3+b];
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      r = root_of(tr + ONE);
      d = 2 * r;
      q[0] = (r + 1) >>> 1;
      q[1] = round_div((m[2][1] - m[1][2]) * ONE, d);
      q[2] = round_div((m[0][2] - m[2][0]) * ONE, d);
      q[3] = round_div((m[1][0] - m[0][1]) * ONE, d);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      r = root_of(m[i][i] - m[j][j] - m[k][k] + ONE);
      d = 2 * r;
      q[1+i] = (r + 1) >>> 1;
      q[0] = round_div((m[k][j] - m[j][k]) * ONE, d);
      q[1+j] = round_div((m[j][i] + m[i][j]) * ONE, d);
      q[1+k] = round_div((m[k][i] + m[i][k]) * ONE, d);
    end
    o.qw = clamp_one(q[0]);
    o.qx = clamp_one(q[1]);
    o.qy = clamp_one(q[2]);
    o.qz = clamp_one(q[3]);
    return o;
  endfunction

  function automatic mat_t diag(int a, int b, int c);
    mat_t t;
    foreach (t.m[n]) t.m[n] = '0;
    t.m[0] = elem_t'(a);
    t.m[4] = elem_t'(b);
    t.m[8] = elem_t'(c);
    return t;
  endfunction

  function automatic quat_t qv(int w, int x, int y, int z);
    quat_t o;
    o.qw = elem_t'(w);
    o.qx = elem_t'(x);
    o.qy = elem_t'(y);
    o.qz = elem_t'(z);
    return o;
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 9))
      0: return elem_t'($urandom());
      1: return elem_t'(ONE);
      2: return elem_t'(-ONE);
      3: return elem_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
      default: return elem_t'(int'($urandom_range(0, 2 * ONE)) - ONE);
    endcase
  endfunction

  function automatic mat_t rand_rotation();
    real a, b, c, ca, sa, cb, sb, cc, sc;
    real r [9];
    mat_t t;
    a = $urandom_range(0, 62831) / 10000.0;
    b = $urandom_range(0, 62831) / 10000.0;
    c = $urandom_range(0, 62831) / 10000.0;
    ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b); cc = $cos(c); sc = $sin(c);
    r[0] = ca*cb; r[1] = ca*sb*sc - sa*cc; r[2] = ca*sb*cc + sa*sc;
    r[3] = sa*cb; r[4] = sa*sb*sc + ca*cc; r[5] = sa*sb*cc - ca*sc;
    r[6] = -sb;   r[7] = cb*sc;            r[8] = cb*cc;
    foreach (r[n]) t.m[n] = elem_t'($rtoi(r[n] * ONE));
    return t;
  endfunction

  task automatic send(mat_t t);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      mat_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    mat_if.valid <= 1'b1;
    {mat_if.m00, mat_if.m01, mat_if.m02} <= {t.m[0], t.m[1], t.m[2]};
    {mat_if.m10, mat_if.m11, mat_if.m12} <= {t.m[3], t.m[4], t.m[5]};
    {mat_if.m20, mat_if.m21, mat_if.m22} <= {t.m[6], t.m[7], t.m[8]};
    do @(posedge clk_i); while (!mat_if.ready);
    quat_due.push_back(to_quat(t));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (quat_if.valid && quat_if.ready) begin
        if (quat_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, quat_if.qw);
          fail <= 1'b1;
        end else begin
          quat_t e;
          e = quat_due.pop_front();
          if (e != {quat_if.qw, quat_if.qx, quat_if.qy, quat_if.qz}) begin
            $display("%0t: mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d", $time,
                     e.qw, e.qx, e.qy, e.qz, quat_if.qw, quat_if.qx, quat_if.qy, quat_if.qz);
            fail <= 1'b1;
          end
        end
      end
      // output stalls come in bursts of random length, counted down in stall_n
      if (quiet || (stall_n == 0 && $urandom_range(0, 5) != 0)) begin
        quat_if.ready <= 1'b1;
        stall_n <= 0;
      end else if (stall_n == 0) begin
        quat_if.ready <= 1'b0;
        stall_n <= $urandom_range(0, 3);
      end else begin
        quat_if.ready <= 1'b0;
        stall_n <= stall_n - 1;
      end
    end
  end

  initial begin
    row_t rw;
    mat_t t;
    mat_if.valid = 1'b0;
    quat_if.ready = 1'b0;
    {mat_if.m00, mat_if.m01, mat_if.m02, mat_if.m10, mat_if.m11} = '0;
    {mat_if.m12, mat_if.m20, mat_if.m21, mat_if.m22} = '0;
    rw.chk = 1'b1;
    rw.m = diag(ONE, ONE, ONE); rw.q = qv(ONE, 0, 0, 0); table_q.push_back(rw);
    rw.m = diag(ONE, -ONE, -ONE); rw.q = qv(0, ONE, 0, 0); table_q.push_back(rw);
    rw.m = diag(-ONE, ONE, -ONE); rw.q = qv(0, 0, ONE, 0); table_q.push_back(rw);
    rw.m = diag(-ONE, -ONE, ONE); rw.q = qv(0, 0, 0, ONE); table_q.push_back(rw);
    rw.chk = 1'b0;
    rw.m = diag(0, 0, 0); table_q.push_back(rw);
    rw.m = diag(-32768, -32768, -32768); table_q.push_back(rw);
    rw.m = diag(32767, 32767, 32767); table_q.push_back(rw);
    rw.m = diag(32767, -32768, -32768); table_q.push_back(rw);
    rw.m = diag(0, 5, 5); table_q.push_back(rw);
    rw.m = diag(1, 0, 0); table_q.push_back(rw);
    foreach (rw.m.m[n]) rw.m.m[n] = 16'sh7fff; table_q.push_back(rw);
    foreach (rw.m.m[n]) rw.m.m[n] = 16'sh8000; table_q.push_back(rw);
    foreach (rw.m.m[n]) rw.m.m[n] = (n % 2) ? 16'sh8000 : 16'sh7fff; table_q.push_back(rw);
    foreach (rw.m.m[n]) rw.m.m[n] = (n % 4) ? 16'sh7fff : 16'sh8000; table_q.push_back(rw);
    for (int n = 0; n < 6; n++) begin
      rw.m = rand_rotation(); table_q.push_back(rw);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (table_q[n]) begin
      send(table_q[n].m);
      if (table_q[n].chk) begin
        void'(quat_due.pop_back());
        quat_due.push_back(table_q[n].q);
      end
    end
    for (int n = 0; n < 1830; n++) begin
      if (n == 400) begin
        mat_if.valid <= 1'b0;
        while (quat_due.size() != 0) @(posedge clk_i);
      end
      if (n == 1600) quiet = 1'b1;
      if ($urandom_range(0, 3) == 0) foreach (t.m[e]) t.m[e] = rand_elem();
      else t = rand_rotation();
      send(t);
    end
    mat_if.valid <= 1'b0;
    while (quat_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (!fail) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: rotation_matrix_to_quaternion.f
+incdir+hw/rtl
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_if.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_sqrt.sv
hw/rtl/rmq_div.sv
hw/rtl/rotation_matrix_to_quaternion.sv
dv/tb.sv
